// File: rtl/core/pfrt_pkg.sv
// ----------------------------------------------------------------------------
// pfrt_pkg
// Types, codes and widths shared by the packet filter rule table and its cells.
// ----------------------------------------------------------------------------
package pfrt_pkg;

	// default table depth
	localparam int DEFAULT_MAX_RULES = 64;

	// field widths
	localparam int CMD_W    = 3;
	localparam int PROT_W   = 3;
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int RN_W     = 8;
	localparam int NUMBER_W = 7;

	// protocol flag positions
	localparam int FLAG_IP  = 0;
	localparam int FLAG_UDP = 1;
	localparam int FLAG_TCP = 2;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 3'd0,
		CMD_DEL_NUM  = 3'd1,
		CMD_DEL_ADDR = 3'd2,
		CMD_DEL_PORT = 3'd3,
		CMD_MATCH    = 3'd4
	} cmd_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FOLD,
		ST_COMPACT,
		ST_DONE
	} state_t;

	// input item without the command, last-declared field in the low bits
	typedef struct packed {
		logic [PORT_W-1:0] filter_port;
		logic [ADDR_W-1:0] filter_addr;
		logic [RN_W-1:0]   rule_number;
		logic [PORT_W-1:0] dst_port;
		logic [PORT_W-1:0] src_port;
		logic [ADDR_W-1:0] dst_addr;
		logic [ADDR_W-1:0] src_addr;
		logic [PROT_W-1:0] protocol_flags;
	} item_t;

	// one stored rule
	typedef struct packed {
		logic [PORT_W-1:0] dst_port;
		logic [PORT_W-1:0] src_port;
		logic [ADDR_W-1:0] dst_addr;
		logic [ADDR_W-1:0] src_addr;
		logic [PROT_W-1:0] protocol;
	} rule_t;

	// result item, status in the low bit
	typedef struct packed {
		logic [NUMBER_W-1:0] rules_held;
		logic [NUMBER_W-1:0] assigned_number;
		logic                verdict;
		logic                status;
	} result_t;

	// per-cell control from the controller
	typedef struct packed {
		logic eval;
		logic compact;
		logic occupied;
		logic write;
		logic pick;
		logic pair_right;
		logic pair_left;
	} cell_ctrl_t;

endpackage

// File: rtl/core/pfrt_cell.sv
// ----------------------------------------------------------------------------
// pfrt_cell
// One rule slot: holds a rule, compares it against the current item and
// trades places with a neighbor during compaction.
// ----------------------------------------------------------------------------
module pfrt_cell import pfrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cmd_t       cmd,
	input  item_t      item,
	input  rule_t      left_rule,
	input  logic       left_live,
	input  rule_t      right_rule,
	input  logic       right_live,
	output rule_t      rule,
	output logic       live,
	output logic       hit,
	output logic       mark
);

	rule_t rule_q;
	logic  live_q;
	logic  hit_q;
	logic  mark_q;

	logic ip_both;
	logic udp_both;
	logic tcp_both;
	logic addr_eq;
	logic port_eq;
	logic hit_c;
	logic mark_c;
	logic take_right;
	logic take_left;

	// packet compare against the stored rule
	always_comb begin
		ip_both  = item.protocol_flags[FLAG_IP]  && rule_q.protocol[FLAG_IP];
		udp_both = item.protocol_flags[FLAG_UDP] && rule_q.protocol[FLAG_UDP];
		tcp_both = item.protocol_flags[FLAG_TCP] && rule_q.protocol[FLAG_TCP];
		addr_eq  = (rule_q.src_addr == item.src_addr) || (rule_q.dst_addr == item.dst_addr);
		port_eq  = (rule_q.src_port == item.src_port) || (rule_q.dst_port == item.dst_port);
		hit_c    = (ip_both && addr_eq) || ((udp_both || tcp_both) && port_eq);
	end

	// delete selection
	always_comb begin
		case (cmd)
			CMD_DEL_NUM:  mark_c = ctrl.occupied && ctrl.pick;
			CMD_DEL_ADDR: mark_c = ctrl.occupied &&
				((rule_q.src_addr == item.filter_addr) ||
				 (rule_q.dst_addr == item.filter_addr));
			CMD_DEL_PORT: mark_c = ctrl.occupied &&
				((rule_q.src_port == item.filter_port) ||
				 (rule_q.dst_port == item.filter_port));
			default:      mark_c = 1'b0;
		endcase
	end

	// odd-even swap: a hole moves right past a live neighbor
	assign take_right = ctrl.compact && ctrl.pair_right && !live_q && right_live;
	assign take_left  = ctrl.compact && ctrl.pair_left && !left_live && live_q;

	// rule storage
	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			rule_q.protocol <= item.protocol_flags;
			rule_q.src_addr <= item.src_addr;
			rule_q.dst_addr <= item.dst_addr;
			rule_q.src_port <= item.src_port;
			rule_q.dst_port <= item.dst_port;
		end else if (take_right) begin
			rule_q <= right_rule;
		end else if (take_left) begin
			rule_q <= left_rule;
		end
	end

	// cell flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			hit_q  <= 1'b0;
			mark_q <= 1'b0;
		end else if (ctrl.eval) begin
			hit_q  <= ctrl.occupied && hit_c;
			mark_q <= mark_c;
			live_q <= ctrl.occupied && !mark_c;
		end else if (take_right) begin
			live_q <= 1'b1;
		end else if (take_left) begin
			live_q <= 1'b0;
		end
	end

	assign rule = rule_q;
	assign live = live_q;
	assign hit  = hit_q;
	assign mark = mark_q;

endmodule

// File: rtl/core/packet_filter_rule_table.sv
// ----------------------------------------------------------------------------
// packet_filter_rule_table
// Ordered firewall rule table built as a row of rule cells, with add, delete
// and packet match commands.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ group: s_tuser carries the command, s_tdata the
// rule, packet and delete arguments. One result per command leaves on the m_
// group: status, verdict, assigned number and rule count after the command.
// One command is worked at a time. Add, match and unknown commands pass
// after the input transfer through an evaluate state, where every cell
// compares in parallel, a fold state for the per-cell hit and delete flags,
// and a done state that loads the output register.
// The three delete commands add an odd-even compaction state before done,
// in which holes left by deleted rules travel right through the row while
// surviving rules keep their order.
// Reset empties the table at once (rule count zero); no clearing pass.
// A result waiting on a stalled receiver does not block the next input
// transfer; that command then holds its own result until the output frees.
// ----------------------------------------------------------------------------
module packet_filter_rule_table import pfrt_pkg::*; #(
	parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tuser: cmd[2:0]
	input  logic [2:0]   s_tuser,
	// s_tdata: protocol_flags[2:0], src_addr[34:3], dst_addr[66:35],
	// src_port[82:67], dst_port[98:83], rule_number[106:99],
	// filter_addr[138:107], filter_port[154:139], zero fill [159:155]
	input  logic [159:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m_tdata: status[0], verdict[1], assigned_number[8:2], rules_held[15:9]
	output logic [15:0]  m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready
);

	localparam int CNT_W  = $clog2(MAX_RULES + 1);
	localparam int ITEM_W = $bits(item_t);

	state_t state_q;
	state_t state_d;

	cmd_t                 cmd_s1;
	item_t                item_s1;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     step_q;
	logic [MAX_RULES-1:0] mark_sr_q;
	logic                 any_q;
	logic                 status_q;
	logic [NUMBER_W-1:0]  assigned_q;
	logic                 verdict_q;
	logic                 m_tvalid_q;
	result_t              m_data_q;

	logic accept;
	logic out_free;
	logic is_delete;
	logic room;
	logic add_en;
	logic eval_en;
	logic fold_en;
	logic compact_en;
	logic done_en;
	logic last_step;

	cell_ctrl_t           ctrl   [MAX_RULES];
	rule_t                rule_a [MAX_RULES];
	rule_t                left_a [MAX_RULES];
	rule_t                right_a[MAX_RULES];
	logic [MAX_RULES-1:0] live_v;
	logic [MAX_RULES-1:0] left_live_v;
	logic [MAX_RULES-1:0] right_live_v;
	logic [MAX_RULES-1:0] hit_v;
	logic [MAX_RULES-1:0] mark_v;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign is_delete = cmd_s1 inside {CMD_DEL_NUM, CMD_DEL_ADDR, CMD_DEL_PORT};
	assign room      = count_q < CNT_W'(MAX_RULES);
	assign add_en    = eval_en && (cmd_s1 == CMD_ADD) && room;
	assign last_step = step_q == CNT_W'(MAX_RULES - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept) state_d = ST_EVAL;
			ST_EVAL:    state_d = ST_FOLD;
			ST_FOLD:    state_d = is_delete ? ST_COMPACT : ST_DONE;
			ST_COMPACT: if (last_step) state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// state decodes
	always_comb begin
		s_tready   = 1'b0;
		eval_en    = 1'b0;
		fold_en    = 1'b0;
		compact_en = 1'b0;
		done_en    = 1'b0;
		case (state_q)
			ST_IDLE:    s_tready   = 1'b1;
			ST_EVAL:    eval_en    = 1'b1;
			ST_FOLD:    fold_en    = 1'b1;
			ST_COMPACT: compact_en = 1'b1;
			ST_DONE:    done_en    = out_free;
			default:    s_tready   = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			step_q     <= '0;
			mark_sr_q  <= '0;
			any_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (add_en) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (fold_en) begin
				mark_sr_q <= mark_v;
				any_q     <= 1'b0;
				step_q    <= '0;
			end
			if (compact_en) begin
				// one delete flag counted per cycle
				count_q   <= count_q - CNT_W'(mark_sr_q[0]);
				any_q     <= any_q || mark_sr_q[0];
				mark_sr_q <= mark_sr_q >> 1;
				step_q    <= CNT_W'(step_q + 1'b1);
			end
			if (done_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(s_tuser[CMD_W-1:0]);
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
		if (eval_en) begin
			assigned_q <= '0;
			case (cmd_s1)
				CMD_ADD: begin
					status_q <= room ? STATUS_OK : STATUS_FAIL;
					if (room) begin
						assigned_q <= NUMBER_W'(CNT_W'(count_q + 1'b1));
					end
				end
				CMD_MATCH: status_q <= STATUS_OK;
				default:   status_q <= STATUS_FAIL;
			endcase
		end
		if (fold_en) begin
			verdict_q <= (cmd_s1 == CMD_MATCH) && (|hit_v);
		end
		if (done_en) begin
			m_data_q.status          <= is_delete ? (any_q ? STATUS_OK : STATUS_FAIL)
			                                      : status_q;
			m_data_q.verdict         <= verdict_q;
			m_data_q.assigned_number <= assigned_q;
			m_data_q.rules_held      <= NUMBER_W'(count_q);
		end
	end

	assign m_tdata  = m_data_q;
	assign m_tvalid = m_tvalid_q;

	// row of rule cells
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		assign ctrl[i] = '{
			eval:       eval_en,
			compact:    compact_en,
			occupied:   CNT_W'(i) < count_q,
			write:      add_en && (CNT_W'(i) == count_q),
			pick:       RN_W'(i + 1) == item_s1.rule_number,
			pair_right: (i < MAX_RULES - 1) && (1'(i) == step_q[0]),
			pair_left:  (i > 0) && (1'(i) != step_q[0])
		};

		// neighbor links: the head sees a live left slot, the tail an empty right slot
		if (i == 0) begin : g_head
			assign left_a[i]      = rule_a[i];
			assign left_live_v[i] = 1'b1;
		end else begin : g_left
			assign left_a[i]      = rule_a[i-1];
			assign left_live_v[i] = live_v[i-1];
		end
		if (i == MAX_RULES - 1) begin : g_tail
			assign right_a[i]      = rule_a[i];
			assign right_live_v[i] = 1'b0;
		end else begin : g_right
			assign right_a[i]      = rule_a[i+1];
			assign right_live_v[i] = live_v[i+1];
		end

		pfrt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.cmd        (cmd_s1),
			.item       (item_s1),
			.left_rule  (left_a[i]),
			.left_live  (left_live_v[i]),
			.right_rule (right_a[i]),
			.right_live (right_live_v[i]),
			.rule       (rule_a[i]),
			.live       (live_v[i]),
			.hit        (hit_v[i]),
			.mark       (mark_v[i])
		);
	end

	// rule count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RULES))
		else $error("rule count above table depth");

	// a successful add grows the count by one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		add_en |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("add did not grow rule count");

	// compaction never grows the count
	a_compact_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		compact_en |=> count_q <= $past(count_q))
		else $error("rule count grew during compaction");

	// a finished command always presents its result
	a_done_presents: assert property (@(posedge clk) disable iff (!arst_n)
		done_en |=> m_tvalid)
		else $error("result not presented");

	// no new command while a delete compaction runs
	a_busy_compact: assert property (@(posedge clk) disable iff (!arst_n)
		compact_en |-> !s_tready)
		else $error("input open during compaction");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_filter_rule_table. Commands go in on the s_
// stream and every result on the m_ stream is compared with a behavioral
// model of the rule table kept inside the bench. Directed commands cover the
// field extremes and the failure cases. Random phases follow, with addresses
// and ports drawn mostly from small pools so that deletes and matches hit
// often. Separate tests fill the table to the limit, stall the output for a
// long stretch, and let the sender pause until the results have drained.
// ----------------------------------------------------------------------------
module testbench;
	import pfrt_pkg::*;

	localparam int MAX_RULES    = DEFAULT_MAX_RULES;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 2 * MAX_RULES + 20;
	localparam int MAX_REPORTS  = 10;

	// command codes the block does not know
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

	logic         clk;
	logic         arst_n;
	logic [2:0]   s_tuser;
	logic [159:0] s_tdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  m_tdata;
	logic         m_tvalid;
	logic         m_tready;

	// rule table as the bench sees it
	rule_t   rule_mem [MAX_RULES];
	int      rule_total;
	result_t pending_results [$];
	int      fail_count;
	bit      idle_on;
	bit      stall_request;

	packet_filter_rule_table #(
		.MAX_RULES(MAX_RULES)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#10_000_000;
		$display("packet_filter_rule_table test failed");
		$finish;
	end

	// apply one command to the table, return the result it should give
	function automatic result_t apply_command(logic [CMD_W-1:0] code, item_t it);
		result_t r;
		bit      drop [MAX_RULES];
		int      removed;
		int      w;
		logic    ip_both;
		logic    port_both;
		logic    addr_eq;
		logic    port_eq;
		r = '0;
		r.status = STATUS_FAIL;
		for (int i = 0; i < MAX_RULES; i++)
			drop[i] = 1'b0;
		case (code)
			CMD_ADD: begin
				if (rule_total < MAX_RULES) begin
					rule_mem[rule_total].protocol = it.protocol_flags;
					rule_mem[rule_total].src_addr = it.src_addr;
					rule_mem[rule_total].dst_addr = it.dst_addr;
					rule_mem[rule_total].src_port = it.src_port;
					rule_mem[rule_total].dst_port = it.dst_port;
					rule_total++;
					r.assigned_number = NUMBER_W'(rule_total);
					r.status = STATUS_OK;
				end
			end
			CMD_DEL_NUM: begin
				if (it.rule_number >= 1 && int'(it.rule_number) <= rule_total) begin
					drop[it.rule_number - 1] = 1'b1;
					r.status = STATUS_OK;
				end
			end
			CMD_DEL_ADDR: begin
				for (int i = 0; i < rule_total; i++)
					drop[i] = (rule_mem[i].src_addr == it.filter_addr) ||
						(rule_mem[i].dst_addr == it.filter_addr);
			end
			CMD_DEL_PORT: begin
				for (int i = 0; i < rule_total; i++)
					drop[i] = (rule_mem[i].src_port == it.filter_port) ||
						(rule_mem[i].dst_port == it.filter_port);
			end
			CMD_MATCH: begin
				r.status = STATUS_OK;
				for (int i = 0; i < rule_total; i++) begin
					ip_both   = it.protocol_flags[FLAG_IP] & rule_mem[i].protocol[FLAG_IP];
					port_both = (it.protocol_flags[FLAG_UDP] & rule_mem[i].protocol[FLAG_UDP]) |
						(it.protocol_flags[FLAG_TCP] & rule_mem[i].protocol[FLAG_TCP]);
					addr_eq   = (rule_mem[i].src_addr == it.src_addr) ||
						(rule_mem[i].dst_addr == it.dst_addr);
					port_eq   = (rule_mem[i].src_port == it.src_port) ||
						(rule_mem[i].dst_port == it.dst_port);
					if ((ip_both && addr_eq) || (port_both && port_eq))
						r.verdict = 1'b1;
				end
			end
			default: ;
		endcase
		// close the holes, keeping order
		removed = 0;
		w = 0;
		for (int i = 0; i < rule_total; i++) begin
			if (drop[i]) begin
				removed++;
			end else begin
				rule_mem[w] = rule_mem[i];
				w++;
			end
		end
		rule_total = w;
		if (code == CMD_DEL_ADDR || code == CMD_DEL_PORT)
			r.status = (removed > 0) ? STATUS_OK : STATUS_FAIL;
		r.rules_held = NUMBER_W'(rule_total);
		return r;
	endfunction

	task automatic note_failure(input string what, input result_t exp, input result_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t %0s: expected status %0d verdict %0d number %0d held %0d, got status %0d verdict %0d number %0d held %0d",
				$realtime, what, exp.status, exp.verdict, exp.assigned_number, exp.rules_held,
				got.status, got.verdict, got.assigned_number, got.rules_held);
	endtask

	// predict on every input transfer, check every output transfer
	always @(posedge clk) begin
		result_t exp;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_command(s_tuser, item_t'(s_tdata[$bits(item_t)-1:0])));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (pending_results.size() == 0) begin
					note_failure("result with nothing pending", '0, got);
				end else begin
					exp = pending_results.pop_front();
					if (got.status !== exp.status || got.verdict !== exp.verdict ||
							got.assigned_number !== exp.assigned_number ||
							got.rules_held !== exp.rules_held)
						note_failure("result mismatch", exp, got);
				end
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// receiver: random ready gaps, or one long counted hold-off on request
	initial begin
		int gap;
		int stall_cnt;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_tready <= 1'b0;
				for (stall_cnt = 1; stall_cnt < STALL_CYCLES; stall_cnt++)
					@(negedge clk);
				stall_request = 1'b0;
			end else begin
				m_tready <= 1'b1;
				gap = pick_gap();
				repeat (gap) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// one command transfer, after a random gap
	task automatic send_item(input logic [CMD_W-1:0] code, input item_t it);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {{($bits(s_tdata) - $bits(item_t)){1'b0}}, it};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_fields(input logic [CMD_W-1:0] code, input logic [PROT_W-1:0] prot,
			input logic [ADDR_W-1:0] sa, input logic [ADDR_W-1:0] da,
			input logic [PORT_W-1:0] sp, input logic [PORT_W-1:0] dp,
			input logic [RN_W-1:0] num, input logic [ADDR_W-1:0] fa,
			input logic [PORT_W-1:0] fp);
		item_t it;
		it.protocol_flags = prot;
		it.src_addr       = sa;
		it.dst_addr       = da;
		it.src_port       = sp;
		it.dst_port       = dp;
		it.rule_number    = num;
		it.filter_addr    = fa;
		it.filter_port    = fp;
		send_item(code, it);
	endtask

	// lower valid and wait until every result is back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] pick_addr();
		if ($urandom_range(3) == 0)
			return $urandom();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'h0A00_0001;
			3: return 32'h0A00_0002;
			4: return 32'hC0A8_0001;
			5: return 32'hC0A8_00FE;
			6: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic logic [PORT_W-1:0] pick_port();
		if ($urandom_range(3) == 0)
			return PORT_W'($urandom());
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 16'd22;
			3: return 16'd53;
			4: return 16'd80;
			5: return 16'd443;
			6: return 16'h8000;
			default: return 16'd8080;
		endcase
	endfunction

	// random item, often reusing fields of a stored rule so that hits happen
	function automatic item_t make_item(logic [CMD_W-1:0] code);
		item_t it;
		int    k;
		it.protocol_flags = PROT_W'($urandom_range(7));
		it.src_addr       = pick_addr();
		it.dst_addr       = pick_addr();
		it.src_port       = pick_port();
		it.dst_port       = pick_port();
		it.filter_addr    = pick_addr();
		it.filter_port    = pick_port();
		if (rule_total > 0 && $urandom_range(3) != 0)
			it.rule_number = RN_W'($urandom_range(rule_total + 1));
		else
			it.rule_number = RN_W'($urandom_range(255));
		if (rule_total > 0 && $urandom_range(1) == 1) begin
			k = $urandom_range(rule_total - 1);
			if (code == CMD_MATCH) begin
				if ($urandom_range(1)) it.src_addr = rule_mem[k].src_addr;
				if ($urandom_range(1)) it.dst_addr = rule_mem[k].dst_addr;
				if ($urandom_range(1)) it.src_port = rule_mem[k].src_port;
				if ($urandom_range(1)) it.dst_port = rule_mem[k].dst_port;
			end
			it.filter_addr = $urandom_range(1) ? rule_mem[k].src_addr : rule_mem[k].dst_addr;
			it.filter_port = $urandom_range(1) ? rule_mem[k].src_port : rule_mem[k].dst_port;
		end
		return it;
	endfunction

	// command mix: a little noise, then add / delete / match by weight
	function automatic logic [CMD_W-1:0] pick_code(int w_add, int w_del);
		int r;
		if ($urandom_range(99) < 4) begin
			case ($urandom_range(2))
				0: return CMD_SPARE_A;
				1: return CMD_SPARE_B;
				default: return CMD_SPARE_C;
			endcase
		end
		r = $urandom_range(99);
		if (r < w_add)
			return CMD_ADD;
		if (r < w_add + w_del) begin
			case ($urandom_range(2))
				0: return CMD_DEL_NUM;
				1: return CMD_DEL_ADDR;
				default: return CMD_DEL_PORT;
			endcase
		end
		return CMD_MATCH;
	endfunction

	task automatic send_random(input logic [CMD_W-1:0] code);
		send_item(code, make_item(code));
	endtask

	// empty table, field extremes, each protocol, each failure case
	task automatic test_directed();
		send_fields(CMD_MATCH, 3'b111, '0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd1, '0, '0);
		send_fields(CMD_DEL_ADDR, '0, '0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_DEL_PORT, '0, '0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_ADD, 3'b111, '0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_ADD, 3'b111, '1, '1, '1, '1, '1, '1, '1);
		send_fields(CMD_ADD, 3'b001, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd81, '0, '0, '0);
		send_fields(CMD_ADD, 3'b010, 32'h0A00_0003, 32'h0A00_0004, 16'd53, 16'd54, '0, '0, '0);
		send_fields(CMD_ADD, 3'b100, 32'h0A00_0005, 32'h0A00_0006, 16'd443, 16'd8080, '0, '0, '0);
		send_fields(CMD_ADD, 3'b000, 32'h0A00_0001, 32'h0A00_0001, 16'd22, 16'd22, '0, '0, '0);
		// ip hit on source address
		send_fields(CMD_MATCH, 3'b001, 32'h0A00_0001, 32'hDEAD_BEEF, 16'd1, 16'd2, '0, '0, '0);
		// packet with no flags
		send_fields(CMD_MATCH, 3'b000, 32'h0A00_0001, 32'h0A00_0002, 16'd22, 16'd22, '0, '0, '0);
		// udp hit on destination port
		send_fields(CMD_MATCH, 3'b010, 32'h1111_1111, 32'h2222_2222, 16'd1000, 16'd54, '0, '0, '0);
		// udp and tcp packet, tcp-only rule hits on source port
		send_fields(CMD_MATCH, 3'b110, 32'h1111_1111, 32'h2222_2222, 16'd443, 16'd1, '0, '0, '0);
		// ip packet that misses every address
		send_fields(CMD_MATCH, 3'b001, 32'h0A00_0007, 32'h0A00_0008, 16'd80, 16'd81, '0, '0, '0);
		// bad rule numbers, then one that exists
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd0, '0, '0);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd7, '0, '0);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd255, '0, '0);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd2, '0, '0);
		send_fields(CMD_DEL_ADDR, '0, '0, '0, '0, '0, '0, 32'h0A00_0002, '0);
		send_fields(CMD_DEL_PORT, '0, '0, '0, '0, '0, '0, '0, 16'd9999);
		send_fields(CMD_DEL_PORT, '0, '0, '0, '0, '0, '0, '0, 16'd22);
		// unknown commands
		send_fields(CMD_SPARE_A, '1, '1, '1, '1, '1, '1, '1, '1);
		send_fields(CMD_SPARE_B, '0, '0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_SPARE_C, 3'b111, '0, '1, '0, '1, 8'd1, '0, '1);
	endtask

	// phases that grow, shrink and hold the table, one without idling
	task automatic test_random_phases();
		int w_add;
		int w_del;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin w_add = 60; w_del = 12; end
				1: begin w_add = 35; w_del = 25; end
				2: begin w_add = 15; w_del = 45; end
				default: begin w_add = 30; w_del = 10; end
			endcase
			idle_on = (p != 5);
			repeat (155)
				send_random(pick_code(w_add, w_del));
			if (p % 3 == 2)
				wait_for_results();
		end
		idle_on = 1'b1;
	endtask

	// fill to the limit, add past it, then drain with every kind of delete
	task automatic test_table_full();
		item_t it;
		repeat (MAX_RULES - rule_total + 4) begin
			it = make_item(CMD_ADD);
			send_item(CMD_ADD, it);
		end
		repeat (6)
			send_random(CMD_MATCH);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, RN_W'(MAX_RULES), '0, '0);
		send_fields(CMD_DEL_NUM, '0, '0, '0, '0, '0, 8'd1, '0, '0);
		send_random(CMD_ADD);
		send_random(CMD_ADD);
		repeat (12) begin
			send_random(CMD_DEL_ADDR);
			send_random(CMD_DEL_PORT);
			send_random(CMD_MATCH);
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_stall();
		wait_for_results();
		stall_request = 1'b1;
		repeat (12)
			send_random(pick_code(50, 20));
		while (stall_request)
			@(posedge clk);
	endtask

	// sender stops until every result is back, several times
	task automatic test_sender_pause();
		repeat (4) begin
			repeat (15)
				send_random(pick_code(40, 25));
			wait_for_results();
		end
	endtask

	task automatic finish_run();
		wait_for_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("packet_filter_rule_table test passed");
		else
			$display("packet_filter_rule_table test failed");
		$finish;
	endtask

	// test sequence
	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = '0;
		s_tdata       = '0;
		rule_total    = 0;
		fail_count    = 0;
		idle_on       = 1'b1;
		stall_request = 1'b0;
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phases();
		test_table_full();
		test_output_stall();
		test_sender_pause();
		finish_run();
	end

endmodule

// File: files.f
rtl/core/pfrt_pkg.sv
rtl/core/pfrt_cell.sv
rtl/core/packet_filter_rule_table.sv
tb/testbench.sv
